[src/imu_binary_packet_deframer_macros.svh]
// Assertion macros used by the deframer RTL (ibpd_burst).
`ifndef IMU_BINARY_PACKET_DEFRAMER_MACROS_SVH
`define IMU_BINARY_PACKET_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define IBPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Checked at every edge, reset included.
`define IBPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBPD_ASSERT(lbl, clk, rstn, prop, msg)
`define IBPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/ibpd_pkg.sv]
package ibpd_pkg;

  localparam int unsigned PACKET_BYTES = 28;
  localparam int unsigned PAYLOAD_LEN  = PACKET_BYTES - 4;
  localparam int unsigned MAX_VALUES   = 12;
  localparam int unsigned NUM_VALUES   =
      ((PAYLOAD_LEN / 2) < MAX_VALUES) ? (PAYLOAD_LEN / 2) : MAX_VALUES;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned CNT_W   = $clog2(PAYLOAD_LEN + 1);
  localparam int unsigned WORD_AW = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
  localparam logic [VAL_W-1:0]  SUM_INIT  = VAL_W'(2 * SYNC_BYTE);

  // Byte write request into the payload word store.
  typedef struct packed {
    logic               en;
    logic               hi;
    logic [WORD_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } wr_req_t;

endpackage

[src/ibpd_ram.sv]
module ibpd_ram import ibpd_pkg::*; (
  input  logic               clk_i,
  input  wr_req_t            wr_i,
  input  logic               rd_en_i,
  input  logic [WORD_AW-1:0] rd_addr_i,
  output logic [VAL_W-1:0]   rd_data_o
);

  logic [VAL_W-1:0] mem_q [NUM_VALUES];
  logic [VAL_W-1:0] rd_data_q;

  // Even payload bytes fill the high half of a word, odd bytes the low half.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.hi) begin
        mem_q[wr_i.addr][VAL_W-1:BYTE_W] <= wr_i.data;
      end else begin
        mem_q[wr_i.addr][BYTE_W-1:0] <= wr_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/ibpd_frame.sv]
module ibpd_frame import ibpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [BYTE_W-1:0] byte_i,
  output wr_req_t           wr_o,
  output logic              start_o
);

  localparam int unsigned WORD_W = CNT_W - 1;

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [VAL_W-1:0]    sum_q, sum_d;
  logic [BYTE_W-1:0]   chk_hi_q, chk_hi_d;
  logic [WORD_W-1:0]   word;

  assign word = cnt_q[CNT_W-1:1];

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    chk_hi_d = chk_hi_q;
    start_o  = 1'b0;
    wr_o     = '0;
    if (acc_i) begin
      case (phase_q)
        PH_HUNT1: begin
          if (byte_i == SYNC_BYTE) begin
            phase_d = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (byte_i == SYNC_BYTE) begin
            phase_d = PH_PAYLOAD;
            cnt_d   = '0;
            sum_d   = SUM_INIT;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_PAYLOAD: begin
          // Bytes past the last emitted value only feed the checksum.
          wr_o.en   = (word < WORD_W'(NUM_VALUES));
          wr_o.hi   = ~cnt_q[0];
          wr_o.addr = word[WORD_AW-1:0];
          wr_o.data = byte_i;
          sum_d     = sum_q + {{(VAL_W-BYTE_W){1'b0}}, byte_i};
          if (cnt_q == CNT_W'(PAYLOAD_LEN - 1)) begin
            phase_d = PH_CHECK;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        PH_CHECK: begin
          if (cnt_q == '0) begin
            chk_hi_d = byte_i;
            cnt_d    = CNT_W'(1);
          end else begin
            start_o = ({chk_hi_q, byte_i} == sum_q);
            phase_d = PH_HUNT1;
            cnt_d   = '0;
          end
        end
        default: begin
          phase_d = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      cnt_q    <= '0;
      sum_q    <= '0;
      chk_hi_q <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      chk_hi_q <= chk_hi_d;
    end
  end

endmodule

[src/ibpd_burst.sv]
`include "imu_binary_packet_deframer_macros.svh"

module ibpd_burst import ibpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  output logic                    rd_en_o,
  output logic [WORD_AW-1:0]      rd_addr_o,
  input  logic [VAL_W-1:0]        rd_data_i,
  output logic                    val_valid_o,
  input  logic                    val_ready_i,
  output logic [CH_W-1:0]         channel_o,
  output logic signed [VAL_W-1:0] raw_value_o,
  output logic                    last_value_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_SHOW
  } state_e;

  state_e             state_q;
  logic [WORD_AW-1:0] idx_q;
  logic [VAL_W-1:0]   raw_q;
  logic               is_last;

  assign is_last = (idx_q == WORD_AW'(NUM_VALUES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      raw_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            idx_q   <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          raw_q   <= rd_data_i;
          state_q <= S_SHOW;
        end
        S_SHOW: begin
          if (val_ready_i) begin
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_FETCH;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign rd_en_o      = (state_q == S_FETCH);
  assign rd_addr_o    = idx_q;
  assign val_valid_o  = (state_q == S_SHOW);
  assign channel_o    = CH_W'(idx_q);
  assign raw_value_o  = raw_q;
  assign last_value_o = val_valid_o & is_last;

  `IBPD_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> (state_q == S_IDLE), "start while busy")
  `IBPD_ASSERT(a_idx_range, clk_i, rst_ni, busy_o |-> (idx_q < WORD_AW'(NUM_VALUES)), "index out of range")
  `IBPD_ASSERT(a_last_ends, clk_i, rst_ni, (val_valid_o && val_ready_i && last_value_o) |=> !busy_o, "burst did not end")
  `IBPD_ASSERT(a_next_fetch, clk_i, rst_ni, (val_valid_o && val_ready_i && !last_value_o) |=> (rd_en_o && (idx_q == $past(idx_q) + 1'b1)), "burst did not advance")
  `IBPD_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !val_valid_o, "result during reset")

endmodule

[src/imu_binary_packet_deframer.sv]
// A good packet shows its first value after the last checksum byte, via the word store read and load steps.
// Each of the 12 values goes through word store read, load and show, plus any output stall.
// Throughput: one byte per cycle while framing; no bytes are taken during a burst.
// Reset (rst_ni low, async): hunt for the first sync byte, checksum and counters
// cleared, no result pending; the payload store is not cleared.
module imu_binary_packet_deframer import ibpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rx_valid_i,
  output logic                    rx_ready_o,
  input  logic [BYTE_W-1:0]       rx_byte_i,
  output logic                    val_valid_o,
  input  logic                    val_ready_i,
  output logic [CH_W-1:0]         channel_o,
  output logic signed [VAL_W-1:0] raw_value_o,
  output logic                    last_value_o
);

  wr_req_t            wr;
  logic               start;
  logic               busy;
  logic               rd_en;
  logic [WORD_AW-1:0] rd_addr;
  logic [VAL_W-1:0]   rd_data;
  logic               rx_acc;

  // Hold off new bytes while a burst drains.
  assign rx_ready_o = ~busy;
  assign rx_acc     = rx_valid_i & rx_ready_o;

  ibpd_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (rx_acc),
    .byte_i  (rx_byte_i),
    .wr_o    (wr),
    .start_o (start)
  );

  ibpd_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ibpd_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .val_valid_o  (val_valid_o),
    .val_ready_i  (val_ready_i),
    .channel_o    (channel_o),
    .raw_value_o  (raw_value_o),
    .last_value_o (last_value_o)
  );

endmodule

[tb/tb_imu_binary_packet_deframer.sv]
module tb_imu_binary_packet_deframer;
  import ibpd_pkg::*;

  localparam int unsigned RUN_LIMIT     = 200000;
  localparam int unsigned RANDOM_BYTES  = 40;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_PAYLOAD,
    TAKE_CHECKSUM
  } frame_phase_e;

  typedef enum int { LEAD_NONE, LEAD_NOISE, LEAD_BROKEN_SYNC } lead_e;
  typedef enum int { FILL_ZERO, FILL_ONES, FILL_MAX, FILL_MIN, FILL_SYNC, FILL_RAMP } fill_e;
  typedef enum int { SUM_GOOD, SUM_BAD_HIGH, SUM_BAD_LOW } sum_fault_e;

  // One directed packet; value is the raw count every channel must show when typed is set.
  typedef struct {
    lead_e                   lead;
    fill_e                   fill;
    sum_fault_e              fault;
    logic                    typed;
    logic signed [VAL_W-1:0] value;
  } packet_case_t;

  typedef struct packed {
    logic [BYTE_W-1:0]       data;
    logic                    typed;
    logic                    typed_fire;
    logic signed [VAL_W-1:0] typed_value;
  } rx_req_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] raw_value;
    logic                    last_value;
  } imu_value_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    rx_valid_i;
  logic                    rx_ready_o;
  logic [BYTE_W-1:0]       rx_byte_i;
  logic                    val_valid_o;
  logic                    val_ready_i;
  logic [CH_W-1:0]         channel_o;
  logic signed [VAL_W-1:0] raw_value_o;
  logic                    last_value_o;

  rx_req_t    rx_meta;
  rx_req_t    rx_stream [$];
  imu_value_t expected_values [$];
  logic [BYTE_W-1:0] body_q [PAYLOAD_LEN];

  // Predictor state
  frame_phase_e      phase_q;
  int unsigned       count_q;
  logic [VAL_W-1:0]  sum_q;
  logic [BYTE_W-1:0] chk_high_q;
  logic [BYTE_W-1:0] payload_q [PAYLOAD_LEN];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  imu_binary_packet_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .val_valid_o (val_valid_o),
    .val_ready_i (val_ready_i),
    .channel_o   (channel_o),
    .raw_value_o (raw_value_o),
    .last_value_o(last_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    val_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic deframe_byte(input rx_req_t r);
    logic [VAL_W-1:0] rx_sum;
    logic             fire;
    imu_value_t       v;
    case (phase_q)
      HUNT_FIRST: begin
        if (r.data == SYNC_BYTE) phase_q = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (r.data == SYNC_BYTE) begin
          phase_q = TAKE_PAYLOAD;
          count_q = 0;
          sum_q   = VAL_W'(2 * SYNC_BYTE);
        end else begin
          phase_q = HUNT_FIRST;
        end
      end
      TAKE_PAYLOAD: begin
        payload_q[count_q] = r.data;
        sum_q = sum_q + VAL_W'(r.data);
        count_q++;
        if (count_q >= PAYLOAD_LEN) begin
          phase_q = TAKE_CHECKSUM;
          count_q = 0;
        end
      end
      default: begin
        if (count_q == 0) begin
          chk_high_q = r.data;
          count_q    = 1;
        end else begin
          rx_sum = {chk_high_q, r.data};
          fire   = r.typed ? r.typed_fire : (rx_sum == sum_q);
          if (fire) begin
            for (int k = 0; k < NUM_VALUES; k++) begin
              v.channel    = CH_W'(k);
              v.raw_value  = r.typed ? r.typed_value : {payload_q[2*k], payload_q[2*k+1]};
              v.last_value = (k == NUM_VALUES - 1);
              expected_values.push_back(v);
            end
          end
          phase_q = HUNT_FIRST;
          count_q = 0;
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    imu_value_t want;
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) begin
        deframe_byte(rx_meta);
      end
      if (val_valid_o && val_ready_i) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected value ch=%0d raw=%0d last=%0b", $time,
                   channel_o, raw_value_o, last_value_o);
          error_count++;
        end else begin
          want = expected_values.pop_front();
          if (channel_o !== want.channel || raw_value_o !== want.raw_value ||
              last_value_o !== want.last_value) begin
            $display("%0t: mismatch expected ch=%0d raw=%0d last=%0b, got ch=%0d raw=%0d last=%0b",
                     $time, want.channel, want.raw_value, want.last_value,
                     channel_o, raw_value_o, last_value_o);
            error_count++;
          end
        end
      end
    end
  end

  task automatic add_byte(input logic [BYTE_W-1:0] data, input logic typed,
                          input logic typed_fire, input logic signed [VAL_W-1:0] tv);
    rx_req_t r;
    r.data        = data;
    r.typed       = typed;
    r.typed_fire  = typed_fire;
    r.typed_value = tv;
    rx_stream.push_back(r);
  endtask

  // Frame body_q with sync and checksum; flip corrupts the checksum.
  task automatic add_packet(input logic [VAL_W-1:0] flip, input logic typed,
                            input logic typed_fire, input logic signed [VAL_W-1:0] tv);
    logic [VAL_W-1:0] sum;
    sum = VAL_W'(2 * SYNC_BYTE);
    add_byte(SYNC_BYTE, typed, typed_fire, tv);
    add_byte(SYNC_BYTE, typed, typed_fire, tv);
    for (int j = 0; j < PAYLOAD_LEN; j++) begin
      add_byte(body_q[j], typed, typed_fire, tv);
      sum = sum + VAL_W'(body_q[j]);
    end
    sum = sum ^ flip;
    add_byte(sum[15:8], typed, typed_fire, tv);
    add_byte(sum[7:0], typed, typed_fire, tv);
  endtask

  task automatic send_request(input rx_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= r.data;
    rx_meta    <= r;
    do @(posedge clk_i); while (!rx_ready_o);
  endtask

  task automatic send_stream();
    while (rx_stream.size() != 0) send_request(rx_stream.pop_front());
  endtask

  // Hold the sender until every outstanding value has drained.
  task automatic wait_drained();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (expected_values.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] random_word();
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h7FFF;
        default: return 16'h8000;
      endcase
    end
    return VAL_W'($urandom);
  endfunction

  packet_case_t packet_cases [8];

  initial begin
    packet_case_t      c;
    logic [VAL_W-1:0]  flip;
    logic [VAL_W-1:0]  w;
    logic [BYTE_W-1:0] b;
    int unsigned       random_sent;
    int unsigned       kind;

    rst_ni             = 1'b0;
    rx_valid_i         = 1'b0;
    rx_byte_i          = '0;
    rx_meta            = '0;
    val_ready_i        = 1'b0;
    error_count        = 0;
    cycle_count        = 0;
    random_sent        = 0;
    phase_q            = HUNT_FIRST;
    count_q            = 0;
    sum_q              = '0;
    chk_high_q         = '0;
    sender_idle_pct    = 32;
    receiver_stall_pct = 55;

    packet_cases = '{
      '{LEAD_NOISE,       FILL_ZERO, SUM_GOOD,     1'b1, 16'sh0000},
      '{LEAD_BROKEN_SYNC, FILL_ONES, SUM_GOOD,     1'b1, 16'shFFFF},
      '{LEAD_NONE,        FILL_MAX,  SUM_GOOD,     1'b1, 16'sh7FFF},
      '{LEAD_NONE,        FILL_MIN,  SUM_GOOD,     1'b1, 16'sh8000},
      '{LEAD_NONE,        FILL_SYNC, SUM_GOOD,     1'b1, 16'sh5555},
      '{LEAD_NONE,        FILL_RAMP, SUM_BAD_HIGH, 1'b1, 16'sh0000},
      '{LEAD_NOISE,       FILL_RAMP, SUM_BAD_LOW,  1'b1, 16'sh0000},
      '{LEAD_NONE,        FILL_RAMP, SUM_GOOD,     1'b0, 16'sh0000}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (packet_cases[i]) begin
      c = packet_cases[i];
      // Swap the idle pattern halfway through the table.
      if (i == 4) begin
        sender_idle_pct    = 55;
        receiver_stall_pct = 32;
      end
      case (c.lead)
        LEAD_NOISE: begin
          add_byte(8'h00, 1'b0, 1'b0, '0);
          add_byte(8'hFF, 1'b0, 1'b0, '0);
          add_byte(8'h54, 1'b0, 1'b0, '0);
        end
        LEAD_BROKEN_SYNC: begin
          add_byte(SYNC_BYTE, 1'b0, 1'b0, '0);
          add_byte(8'hD5, 1'b0, 1'b0, '0);
        end
        default: ;
      endcase
      for (int j = 0; j < PAYLOAD_LEN; j++) begin
        case (c.fill)
          FILL_ZERO: body_q[j] = 8'h00;
          FILL_ONES: body_q[j] = 8'hFF;
          FILL_MAX:  body_q[j] = j[0] ? 8'hFF : 8'h7F;
          FILL_MIN:  body_q[j] = j[0] ? 8'h00 : 8'h80;
          FILL_SYNC: body_q[j] = SYNC_BYTE;
          default:   body_q[j] = BYTE_W'(j * 11 + 3);
        endcase
      end
      case (c.fault)
        SUM_BAD_HIGH: flip = 16'h8000;
        SUM_BAD_LOW:  flip = 16'h0001;
        default:      flip = 16'h0000;
      endcase
      add_packet(flip, c.typed, c.fault == SUM_GOOD, c.value);
      send_stream();
    end
    wait_drained();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    while (random_sent < RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 84) begin
        for (int j = 0; j + 1 < PAYLOAD_LEN; j += 2) begin
          w = random_word();
          body_q[j]     = w[15:8];
          body_q[j + 1] = w[7:0];
        end
        if (PAYLOAD_LEN % 2 != 0) body_q[PAYLOAD_LEN - 1] = BYTE_W'($urandom);
        flip = (kind < 72) ? 16'h0000 : VAL_W'($urandom_range(1, 16'hFFFF));
        add_packet(flip, 1'b0, 1'b0, '0);
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom), 1'b0, 1'b0, '0);
      end else begin
        b = BYTE_W'($urandom);
        if (b == SYNC_BYTE) b = ~b;
        add_byte(SYNC_BYTE, 1'b0, 1'b0, '0);
        add_byte(b, 1'b0, 1'b0, '0);
      end
      random_sent += rx_stream.size();
      send_stream();
      if ($urandom_range(7) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
